@@ hdl/tdpt_pkg.sv @@
// Shared types for the trial division prime test unit.
`timescale 1ns / 1ps

package tdpt_pkg;

    // Sequencer states: wait for a beat, run trial divisions, hand off the verdict
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

@@ hdl/trial_division_prime_test_unit.sv @@
// Trial division (6k +/- 1 wheel) prime test with a bit-serial restoring divider.
// Values 0..3 and even values are settled without dividing; the rest run k trial divisors
//   (3, 5, 7, 11, ...) through the divider, one quotient bit per cycle.
// One candidate at a time: no new beat is taken while one is tested; o_stall stays high until the verdict
//   moves to the output register, which waits while the output beat is stalled.
// Reset: synchronous, active low; clears the sequencer and the output valid, no clearing pass.
`timescale 1ns / 1ps

module trial_division_prime_test_unit #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_candidate,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_tested_value,
    output logic             o_is_prime
);

    // Divisor width: covers every divisor up to just past the square root of the candidate
    localparam int DW = (WIDTH + 1) / 2 + 1;
    localparam int CW = $clog2(WIDTH);
    localparam logic [DW-1:0] FIRST_DIV = DW'(3);
    localparam logic [DW-1:0] SHORT_STEP = DW'(2);
    localparam logic [DW-1:0] LONG_STEP = DW'(4);
    localparam logic [CW-1:0] LAST_BIT = CW'(WIDTH - 1);

    tdpt_pkg::t_state r_state, n_state;

    logic [WIDTH-1:0] r_cand, n_cand;      // candidate under test
    logic [WIDTH-1:0] r_num, n_num;        // dividend bits out, quotient bits in
    logic [DW-1:0]    r_rem, n_rem;        // partial remainder
    logic [DW-1:0]    r_div, n_div;        // current trial divisor
    logic             r_step4, n_step4;    // next wheel step is 4
    logic [CW-1:0]    r_cnt, n_cnt;        // index of the quotient bit in progress
    logic             r_result, n_result;  // verdict waiting for the output register
    logic             r_out_valid, n_out_valid;
    logic [WIDTH-1:0] r_out_value, n_out_value;
    logic             r_out_prime, n_out_prime;

    logic [DW:0]      w_partial;
    logic [DW+1:0]    w_diff;
    logic             w_ge;
    logic             w_in_beat;
    logic             w_out_beat;
    logic             w_out_free;

    // Divider step: bring down one dividend bit, subtract when it fits
    assign w_partial = {r_rem, r_num[WIDTH-1]};
    assign w_diff    = {1'b0, w_partial} - {2'b00, r_div};
    assign w_ge      = ~w_diff[DW+1];

    assign w_in_beat  = i_valid && !o_stall;
    assign w_out_beat = r_out_valid && !i_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    assign o_stall        = (r_state != tdpt_pkg::ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_tested_value = r_out_value;
    assign o_is_prime     = r_out_prime;

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_cand      = r_cand;
        n_num       = r_num;
        n_rem       = r_rem;
        n_div       = r_div;
        n_step4     = r_step4;
        n_cnt       = r_cnt;
        n_result    = r_result;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_prime = r_out_prime;

        // Drop the output beat once it is taken
        if (w_out_beat) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tdpt_pkg::ST_IDLE: begin
                if (w_in_beat) begin
                    n_cand  = i_candidate;
                    n_num   = i_candidate;
                    n_rem   = '0;
                    n_div   = FIRST_DIV;
                    n_step4 = 1'b0;
                    n_cnt   = LAST_BIT;
                    // Settle small and even values without dividing
                    if (i_candidate <= WIDTH'(1)) begin
                        n_result = 1'b0;
                        n_state  = tdpt_pkg::ST_DONE;
                    end else if (i_candidate == WIDTH'(2) || i_candidate == WIDTH'(3)) begin
                        n_result = 1'b1;
                        n_state  = tdpt_pkg::ST_DONE;
                    end else if (!i_candidate[0]) begin
                        n_result = 1'b0;
                        n_state  = tdpt_pkg::ST_DONE;
                    end else begin
                        n_state = tdpt_pkg::ST_DIV;
                    end
                end
            end
            tdpt_pkg::ST_DIV: begin
                n_num = {r_num[WIDTH-2:0], w_ge};
                n_rem = w_ge ? w_diff[DW-1:0] : w_partial[DW-1:0];
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    // Quotient below divisor: divisor squared exceeds candidate
                    if (n_num < {{(WIDTH-DW){1'b0}}, r_div}) begin
                        n_result = 1'b1;
                        n_state  = tdpt_pkg::ST_DONE;
                    end else if (n_rem == '0) begin
                        n_result = 1'b0;
                        n_state  = tdpt_pkg::ST_DONE;
                    end else begin
                        // Advance along the wheel and restart the divider
                        n_div = r_div + (r_step4 ? LONG_STEP : SHORT_STEP);
                        if (r_div != FIRST_DIV) begin
                            n_step4 = ~r_step4;
                        end
                        n_num = r_cand;
                        n_rem = '0;
                        n_cnt = LAST_BIT;
                    end
                end
            end
            tdpt_pkg::ST_DONE: begin
                // Hand the verdict to the output register when it has room
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_cand;
                    n_out_prime = r_result;
                    n_state     = tdpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdpt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cand      <= n_cand;
        r_num       <= n_num;
        r_rem       <= n_rem;
        r_div       <= n_div;
        r_step4     <= n_step4;
        r_cnt       <= n_cnt;
        r_result    <= n_result;
        r_out_value <= n_out_value;
        r_out_prime <= n_out_prime;
    end

`ifndef SYNTHESIS
    // A new output beat only comes from a finished test
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == tdpt_pkg::ST_DONE))
        else $error("output beat without a finished test");

    // Trial divisors are odd and start at three
    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdpt_pkg::ST_DIV) |-> (r_div[0] && r_div >= FIRST_DIV))
        else $error("trial divisor out of sequence");

    // Partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdpt_pkg::ST_DIV) |-> (r_rem < r_div))
        else $error("partial remainder not reduced");

    // Candidate holds while the divider runs
    a_cand_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdpt_pkg::ST_DIV && $past(r_state == tdpt_pkg::ST_DIV))
        |-> $stable(r_cand))
        else $error("candidate changed during test");
`endif

endmodule

@@ tb/trial_division_prime_test_unit_test.sv @@
// Testbench for the trial division prime test unit: directed table, random candidates, idling phases.
`timescale 1ns / 1ps

module trial_division_prime_test_unit_test;

    localparam int WIDTH            = 32;
    localparam int DIRECTED_COUNT   = 22;
    localparam int RANDOM_PER_PHASE = 20;
    // Largest prime below 2^32 scans about 22k trial divisors
    localparam int WATCHDOG_LIMIT   = 3_000_000;
    localparam int TAIL_CYCLES      = 200;

    // One row of the directed table; prime is only meaningful where known is set
    typedef struct packed {
        logic [WIDTH-1:0] value;
        logic             known;
        logic             prime;
    } t_stim_row;

    typedef struct packed {
        logic [WIDTH-1:0] value;
        logic             prime;
    } t_verdict;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [WIDTH-1:0] i_candidate;
    logic             o_valid;
    logic             i_stall;
    logic [WIDTH-1:0] o_tested_value;
    logic             o_is_prime;

    // Verdict that travels with the candidate currently on the input port
    logic             drive_prime;

    t_verdict         pending_verdicts[$];
    int unsigned      n_errors      = 0;
    int unsigned      quiet_cycles  = 0;
    int unsigned      send_idle_pct = 0;
    int unsigned      stall_pct     = 0;

    trial_division_prime_test_unit #(
        .WIDTH(WIDTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_candidate    (i_candidate),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_tested_value (o_tested_value),
        .o_is_prime     (o_is_prime)
    );

    always #4 i_clk = ~i_clk;

    // Decide primality by trial division over the 6k +/- 1 wheel
    function automatic logic trial_division_verdict(input logic [WIDTH-1:0] value);
        longint unsigned n;
        longint unsigned divisor;
        longint unsigned stride;
        n = value;
        if (n <= 1) return 1'b0;
        if (n == 2 || n == 3) return 1'b1;
        if (n % 2 == 0 || n % 3 == 0) return 1'b0;
        divisor = 5;
        stride  = 2;
        // Compare against a quotient so the bound never overflows
        while (divisor <= n / divisor) begin
            if (n % divisor == 0) return 1'b0;
            divisor += stride;
            stride   = 6 - stride;
        end
        return 1'b1;
    endfunction

    // Directed table: extremes, the smallest wheel divisors, prime squares, top of range
    function automatic t_stim_row directed_row(input int idx);
        t_stim_row row;
        case (idx)
            0:  row = '{32'd0,          1'b1, 1'b0};
            1:  row = '{32'd1,          1'b1, 1'b0};
            2:  row = '{32'd2,          1'b1, 1'b1};
            3:  row = '{32'd3,          1'b1, 1'b1};
            4:  row = '{32'd4,          1'b1, 1'b0};
            5:  row = '{32'd5,          1'b0, 1'b0};
            6:  row = '{32'd9,          1'b1, 1'b0};
            7:  row = '{32'd25,         1'b0, 1'b0};
            8:  row = '{32'd35,         1'b0, 1'b0};
            9:  row = '{32'd49,         1'b0, 1'b0};
            10: row = '{32'd121,        1'b0, 1'b0};
            11: row = '{32'd143,        1'b0, 1'b0};
            12: row = '{32'd169,        1'b0, 1'b0};
            13: row = '{32'd289,        1'b0, 1'b0};
            14: row = '{32'd65537,      1'b0, 1'b0};
            15: row = '{32'd1018081,    1'b0, 1'b0};
            16: row = '{32'h5555_5555,  1'b0, 1'b0};
            17: row = '{32'hAAAA_AAAA,  1'b1, 1'b0};
            18: row = '{32'h8000_0000,  1'b1, 1'b0};
            19: row = '{32'hFFFF_FFFE,  1'b1, 1'b0};
            20: row = '{32'hFFFF_FFFF,  1'b1, 1'b0};
            // Largest 32-bit prime: divisor squared wraps past 2^32 at the end of the scan
            21: row = '{32'd4294967291, 1'b1, 1'b1};
            default: row = '0;
        endcase
        return row;
    endfunction

    function automatic int unsigned small_factor(input int unsigned idx);
        case (idx)
            0:  return 2;
            1:  return 3;
            2:  return 5;
            3:  return 7;
            4:  return 11;
            5:  return 13;
            6:  return 17;
            7:  return 19;
            8:  return 23;
            9:  return 29;
            10: return 31;
            11: return 37;
            12: return 61;
            13: return 101;
            14: return 199;
            default: return 251;
        endcase
    endfunction

    // Keep scans short: small values, or wide values with a small factor
    function automatic logic [WIDTH-1:0] pick_candidate();
        int unsigned      roll;
        int unsigned      f;
        int unsigned      g;
        logic [WIDTH-1:0] raw;
        roll = $urandom_range(0, 99);
        raw  = $urandom();
        f    = small_factor($urandom_range(0, 15));
        g    = small_factor($urandom_range(0, 15));
        if (roll < 30) return $urandom_range(0, 300);
        if (roll < 50) return $urandom_range(0, 65535);
        if (roll < 55) return $urandom_range(0, 1 << 20);
        if (roll < 80) return raw - (raw % f);
        if (roll < 90) return f * g;
        return {raw[WIDTH-1:1], 1'b0};
    endfunction

    // Present one candidate beat and hold it until accepted; call at a falling edge
    task automatic send_candidate(input logic [WIDTH-1:0] value, input logic prime);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_candidate <= value;
        drive_prime <= prime;
        @(posedge i_clk);
        while (!(i_valid && !o_stall)) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every outstanding verdict has come back
    task automatic wait_for_verdicts();
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall);
        logic [WIDTH-1:0] value;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            value = pick_candidate();
            send_candidate(value, trial_division_verdict(value));
        end
        wait_for_verdicts();
    endtask

    // Stall the result channel at random
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Record accepted candidates, check results in order, watch for a hang
    always @(posedge i_clk) begin : result_monitor
        t_verdict want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                pending_verdicts.push_back({i_candidate, drive_prime});
            end
            if (o_valid && !i_stall) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: unexpected result beat: tested_value=%0d is_prime=%0b",
                             $time, o_tested_value, o_is_prime);
                    n_errors++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_tested_value !== want.value) begin
                        $display("%0t: tested_value mismatch: expected %0d, actual %0d",
                                 $time, want.value, o_tested_value);
                        n_errors++;
                    end
                    if (o_is_prime !== want.prime) begin
                        $display("%0t: is_prime mismatch for %0d: expected %0b, actual %0b",
                                 $time, want.value, want.prime, o_is_prime);
                        n_errors++;
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, no beat in %0d cycles", $time, quiet_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_stim_row row;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_candidate = '0;
        i_stall     = 1'b0;
        drive_prime = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table, back to back with no idling
        for (int k = 0; k < DIRECTED_COUNT; k++) begin
            row = directed_row(k);
            send_candidate(row.value, row.known ? row.prime : trial_division_verdict(row.value));
        end
        wait_for_verdicts();

        // Random candidates under each idling mix
        run_random_phase(0, 0);
        run_random_phase(75, 0);
        run_random_phase(0, 75);
        run_random_phase(19, 19);

        // Catch stray results after the last verdict
        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
